### rtl/psched_pkg.sv
// ----------------------------------------------------------------------------
// Pump scheduler package
// Status codes, field widths and reset constants for the pump scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

  localparam int unsigned CoolW   = 11;
  localparam int unsigned DutyW   = 12;
  localparam int unsigned SinceW  = 17;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SinceW-1:0] SinceMax     = '1;
  localparam logic [DutyW-1:0]  RunMax       = '1;
  localparam logic [CoolW-1:0]  CoolReset    = CoolW'(15);
  localparam logic [DutyW-1:0]  DutyReset    = DutyW'(300);
  localparam logic [SinceW-1:0] DailyReset   = SinceW'(86400);
  localparam logic [SinceW-1:0] CoolSecReset = SinceW'(15 * 60);

  typedef enum logic [CfgIdxW-1:0] {
    REG_COOLDOWN = 2'd0,
    REG_DUTY     = 2'd1,
    REG_DAILY    = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_t;

  typedef enum logic [StatusW-1:0] {
    ST_NONE        = 3'd0,
    ST_START_REQ   = 3'd1,
    ST_START_DAILY = 3'd2,
    ST_BLOCK_WARM  = 3'd3,
    ST_BLOCK_COOL  = 3'd4,
    ST_STOP_DUTY   = 3'd5,
    ST_STOP_WARM   = 3'd6,
    ST_RSVD        = 3'd7
  } status_t;

  typedef struct packed {
    status_t status;
    logic    pump_on;
  } result_t;

  // minutes to seconds: x * 60 = x * 64 - x * 4
  function automatic logic [SinceW-1:0] min_to_sec(input logic [CoolW-1:0] m);
    logic [SinceW-1:0] ext;
    ext = SinceW'(m);
    return (ext << 6) - (ext << 2);
  endfunction

endpackage

### rtl/pump_run_scheduler.sv
// ----------------------------------------------------------------------------
// Pump run scheduler
// Starts, blocks and stops a circulation pump from per-step sensor beats.
// ----------------------------------------------------------------------------
// One input beat is taken per clock cycle while the skid stage is empty; the
// state update for it is made in the cycle it is accepted. Its result goes to
// the output register, or to the skid stage if the output register holds an
// untaken result. That one-deep skid stage decouples the two sides, so input
// beats keep flowing while a result waits to be taken; the input stalls only
// when both output stages are full. Configuration writes take effect at the
// next beat; the cooldown is held in seconds, converted when it is written.
module pump_run_scheduler
  import psched_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [0] tick, [1] current_detected, [2] rl_warm, [3] rl_warm_event, [7:4] zero
  input  logic [7:0]         s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] pump_on, [3:1] status, [7:4] zero
  output logic [7:0]         m_axis_tdata
);

  logic [SinceW-1:0] cool_sec;
  logic [DutyW-1:0]  duty;
  logic [SinceW-1:0] daily;

  logic              running;
  logic [SinceW-1:0] since_start;
  logic [DutyW-1:0]  run_elapsed;

  logic              running_next;
  logic [SinceW-1:0] since_start_next;
  logic [DutyW-1:0]  run_elapsed_next;
  result_t           res;

  logic              out_valid;
  result_t           out_data;
  logic              skid_valid;
  result_t           skid_data;

  logic tick, req, warm, warm_ev;
  logic acc, take;
  logic [SinceW-1:0] since_inc;
  logic [DutyW-1:0]  run_inc;
  logic              daily_due;

  assign tick    = s_axis_tdata[0];
  assign req     = s_axis_tdata[1];
  assign warm    = s_axis_tdata[2];
  assign warm_ev = s_axis_tdata[3];

  assign s_axis_tready = !skid_valid;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      cool_sec <= CoolSecReset;
      duty     <= DutyReset;
      daily    <= DailyReset;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_COOLDOWN: cool_sec <= min_to_sec(cfg_data[CoolW-1:0]);
        REG_DUTY:     duty     <= cfg_data[DutyW-1:0];
        REG_DAILY:    daily    <= cfg_data[SinceW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    since_inc = (tick && since_start != SinceMax) ? since_start + 1'b1 : since_start;
    run_inc   = (tick && run_elapsed != RunMax) ? run_elapsed + 1'b1 : run_elapsed;
    daily_due = !req && tick && (since_inc >= daily);

    running_next     = running;
    since_start_next = since_inc;
    run_elapsed_next = run_elapsed;
    res.status       = ST_NONE;

    if (running) begin
      run_elapsed_next = run_inc;
      if (warm_ev) begin
        running_next = 1'b0;
        res.status   = ST_STOP_WARM;
      end else if (run_inc >= duty) begin
        running_next = 1'b0;
        res.status   = ST_STOP_DUTY;
      end
    end else if (req || daily_due) begin
      if (warm) begin
        res.status = ST_BLOCK_WARM;
      end else if (since_inc < cool_sec) begin
        res.status = ST_BLOCK_COOL;
      end else begin
        running_next     = 1'b1;
        since_start_next = '0;
        run_elapsed_next = '0;
        res.status       = req ? ST_START_REQ : ST_START_DAILY;
      end
    end
    res.pump_on = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      since_start <= CoolSecReset;
      run_elapsed <= '0;
    end else if (acc) begin
      running     <= running_next;
      since_start <= since_start_next;
      run_elapsed <= run_elapsed_next;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
        if (acc) begin
          out_data <= res;
        end
      end
    end else if (acc) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end
  end

endmodule
